// ----- sv/tcc_pkg.sv -----
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;

    // arithmetic widths, all from the coordinate width (the dividend also from FRAC_BITS)
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;
    localparam int SQS_BITS    = PROD_BITS + 2;
    localparam int SQ_LO_BITS  = SQS_BITS / 2;
    localparam int SQ_HI_BITS  = SQS_BITS - SQ_LO_BITS;
    localparam int VOL_BITS    = DIFF_BITS + CROSS_BITS + 2;
    localparam int VOL_LO_BITS = VOL_BITS / 2;
    localparam int VOL_HI_BITS = VOL_BITS - VOL_LO_BITS;
    localparam int NUM_BITS    = SQS_BITS + CROSS_BITS + 3;
    localparam int DIVD_BITS   = NUM_BITS + FRAC_BITS + 2;
    localparam int DIVS_BITS   = VOL_BITS + 2;

    localparam int CTR_BITS    = 32;
    localparam int QUO_BITS    = CTR_BITS + 1;

    localparam int FRONT_STAGES = 8;
    localparam int DIV_STAGES   = QUO_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [CTR_BITS-1:0]   center_t;
    typedef logic [DIVD_BITS-1:0]         divd_t;
    typedef logic [DIVS_BITS-1:0]         divs_t;

    localparam center_t SAT_POS = {1'b0, {(CTR_BITS-1){1'b1}}};
    localparam center_t SAT_NEG = {1'b1, {(CTR_BITS-1){1'b0}}};
    localparam logic [QUO_BITS-1:0] LIM_POS = {2'b00, {(CTR_BITS-1){1'b1}}};
    localparam logic [QUO_BITS-1:0] LIM_NEG = {2'b01, {(CTR_BITS-1){1'b0}}};

    // dividend/divisor set for the three axes: q = floor(divd / divs)
    typedef struct packed {
        logic [2:0][DIVD_BITS-1:0] divd;
        divs_t                     divs;
        logic [2:0]                neg;
        logic                      coplanar;
    } ratio_t;

endpackage

// ----- sv/tcc_ifs.sv -----
`timescale 1ns / 1ps

interface tcc_in_if import tcc_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t ax, ay, az;
    coord_t bx, by_coord, bz;
    coord_t cx, cy, cz;
    coord_t dx, dy, dz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz,
                    output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
    logic    valid;
    logic    ready;
    center_t center_x, center_y, center_z;
    logic    coplanar;
    logic    saturated;

    modport source (output valid, center_x, center_y, center_z, coplanar, saturated,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, coplanar, saturated,
                    output ready);
endinterface

// ----- sv/tcc_front.sv -----
`timescale 1ns / 1ps

module tcc_front import tcc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t pt [4][3],
    output logic   out_valid,
    input  logic   out_ready,
    output ratio_t ratio
);

    typedef logic signed [DIFF_BITS-1:0]              diff_t;
    typedef logic signed [PROD_BITS-1:0]              prod_t;
    typedef logic signed [CROSS_BITS-1:0]             cross_t;
    typedef logic signed [SQS_BITS-1:0]               sqs_t;
    typedef logic signed [DIFF_BITS+CROSS_BITS-1:0]   vprod_t;
    typedef logic signed [SQ_LO_BITS+CROSS_BITS:0]    plo_t;
    typedef logic signed [SQ_HI_BITS+CROSS_BITS-1:0]  phi_t;
    typedef logic signed [VOL_BITS-1:0]               vol_t;
    typedef logic signed [COORD_BITS+VOL_LO_BITS:0]   vlo_t;
    typedef logic signed [COORD_BITS+VOL_HI_BITS-1:0] vhi_t;
    typedef logic signed [NUM_BITS-1:0]               num_t;

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic [FRONT_STAGES-1:0] en;

    coord_t p0_reg  [1:5][3];
    diff_t  du_reg  [1:3][3];
    diff_t  dv_reg  [3];
    diff_t  dw_reg  [3];
    prod_t  cpa_reg [3][3];
    prod_t  cpb_reg [3][3];
    prod_t  sq_reg  [3][3];
    cross_t cr_reg  [3][3];
    sqs_t   ss_reg  [3];
    vprod_t vp_reg  [3];
    plo_t   mlo_reg [3][3];
    phi_t   mhi_reg [3][3];
    vol_t   vol_reg;
    num_t   t_reg   [3][3];
    num_t   nk_reg  [3];
    vlo_t   pl_reg  [3];
    vhi_t   ph_reg  [3];
    vol_t   vol6_reg;
    num_t   n_reg   [3];
    vol_t   vol7_reg;
    ratio_t ratio_reg;
    ratio_t ratio_next;

    // a stage loads when the output is ready or when it or any stage after it holds a bubble
    for (genvar i = 0; i < FRONT_STAGES; i++) begin : g_en
        assign en[i] = out_ready || !(&vld_reg[FRONT_STAGES-1:i]);
    end

    assign vld_next = {vld_reg[FRONT_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FRONT_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // stage 1: edge vectors from vertex 0
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                p0_reg[1][k] <= pt[0][k];
                du_reg[1][k] <= diff_t'(pt[1][k]) - diff_t'(pt[0][k]);
                dv_reg[k]    <= diff_t'(pt[2][k]) - diff_t'(pt[0][k]);
                dw_reg[k]    <= diff_t'(pt[3][k]) - diff_t'(pt[0][k]);
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        // stage 2: cross product terms and squares
        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                cpa_reg[0][k] <= prod_t'(dv_reg[K1]) * prod_t'(dw_reg[K2]);
                cpb_reg[0][k] <= prod_t'(dv_reg[K2]) * prod_t'(dw_reg[K1]);
                cpa_reg[1][k] <= prod_t'(dw_reg[K1]) * prod_t'(du_reg[1][K2]);
                cpb_reg[1][k] <= prod_t'(dw_reg[K2]) * prod_t'(du_reg[1][K1]);
                cpa_reg[2][k] <= prod_t'(du_reg[1][K1]) * prod_t'(dv_reg[K2]);
                cpb_reg[2][k] <= prod_t'(du_reg[1][K2]) * prod_t'(dv_reg[K1]);
                sq_reg[0][k]  <= prod_t'(du_reg[1][k]) * prod_t'(du_reg[1][k]);
                sq_reg[1][k]  <= prod_t'(dv_reg[k]) * prod_t'(dv_reg[k]);
                sq_reg[2][k]  <= prod_t'(dw_reg[k]) * prod_t'(dw_reg[k]);
                du_reg[2][k]  <= du_reg[1][k];
                p0_reg[2][k]  <= p0_reg[1][k];
            end
        end

        // stage 3: v x w, w x u, u x v
        always_ff @(posedge clk)
        begin
            if (en[2])
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cr_reg[j][k] <= cross_t'(cpa_reg[j][k]) - cross_t'(cpb_reg[j][k]);
                end
                du_reg[3][k] <= du_reg[2][k];
                p0_reg[3][k] <= p0_reg[2][k];
            end
        end

        // stage 4: volume terms; squared lengths split in two halves
        always_ff @(posedge clk)
        begin
            if (en[3])
            begin
                vp_reg[k] <= vprod_t'(du_reg[3][k]) * vprod_t'(cr_reg[0][k]);
                for (int j = 0; j < 3; j++)
                begin
                    mlo_reg[k][j] <= plo_t'($signed({1'b0, ss_reg[j][SQ_LO_BITS-1:0]}))
                                     * plo_t'(cr_reg[j][k]);
                    mhi_reg[k][j] <= phi_t'($signed(ss_reg[j][SQS_BITS-1:SQ_LO_BITS]))
                                     * phi_t'(cr_reg[j][k]);
                end
                p0_reg[4][k] <= p0_reg[3][k];
            end
        end

        // stage 5: recombine halves
        always_ff @(posedge clk)
        begin
            if (en[4])
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t_reg[k][j] <= (num_t'(mhi_reg[k][j]) <<< SQ_LO_BITS)
                                   + num_t'(mlo_reg[k][j]);
                end
                p0_reg[5][k] <= p0_reg[4][k];
            end
        end

        // stage 6: numerator sum; vertex 0 times volume, split in two halves
        always_ff @(posedge clk)
        begin
            if (en[5])
            begin
                nk_reg[k] <= t_reg[k][0] + t_reg[k][1] + t_reg[k][2];
                pl_reg[k] <= vlo_t'(p0_reg[5][k])
                             * vlo_t'($signed({1'b0, vol_reg[VOL_LO_BITS-1:0]}));
                ph_reg[k] <= vhi_t'(p0_reg[5][k])
                             * vhi_t'($signed(vol_reg[VOL_BITS-1:VOL_LO_BITS]));
            end
        end

        // stage 7: full numerator N + 2 a V
        always_ff @(posedge clk)
        begin
            if (en[6])
            begin
                n_reg[k] <= nk_reg[k]
                            + (((num_t'(ph_reg[k]) <<< VOL_LO_BITS) + num_t'(pl_reg[k])) <<< 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                ss_reg[j] <= sqs_t'(sq_reg[j][0]) + sqs_t'(sq_reg[j][1]) + sqs_t'(sq_reg[j][2]);
            end
        end
        if (en[4])
        begin
            vol_reg <= vol_t'(vp_reg[0]) + vol_t'(vp_reg[1]) + vol_t'(vp_reg[2]);
        end
        if (en[5])
        begin
            vol6_reg <= vol_reg;
        end
        if (en[6])
        begin
            vol7_reg <= vol6_reg;
        end
        if (en[7])
        begin
            ratio_reg <= ratio_next;
        end
    end

    // stage 8: magnitudes, rounding offset, signs
    always_comb
    begin
        logic [VOL_BITS-1:0] avol;
        logic [NUM_BITS-1:0] anum [3];
        avol = vol7_reg[VOL_BITS-1] ? -vol7_reg : vol7_reg;
        ratio_next.divs     = divs_t'(avol) << 2;
        ratio_next.coplanar = (vol7_reg == '0);
        for (int k = 0; k < 3; k++)
        begin
            anum[k] = n_reg[k][NUM_BITS-1] ? -n_reg[k] : n_reg[k];
            ratio_next.divd[k] = (divd_t'(anum[k]) << (FRAC_BITS + 1))
                                 + (divd_t'(avol) << 1);
            ratio_next.neg[k]  = n_reg[k][NUM_BITS-1] ^ vol7_reg[VOL_BITS-1];
        end
    end

    assign ratio     = ratio_reg;
    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign in_ready  = en[0];

endmodule

// ----- sv/tcc_div.sv -----
`timescale 1ns / 1ps

module tcc_div import tcc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  ratio_t  ratio,
    output logic    out_valid,
    input  logic    out_ready,
    output center_t ctr [3],
    output logic    coplanar,
    output logic    saturated
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    logic [DIV_STAGES-1:0] en;

    logic [2:0][DIVD_BITS-1:0] rem_reg [0:QUO_BITS-1];
    divs_t                     d_reg   [0:QUO_BITS-1];
    logic [2:0][QUO_BITS-1:0]  q_reg   [1:QUO_BITS];
    logic [2:0]                neg_reg [0:QUO_BITS];
    logic [2:0]                ovf_reg [0:QUO_BITS];
    logic                      cop_reg [0:QUO_BITS];

    center_t ctr_reg [3];
    center_t ctr_next [3];
    logic    cop_out_reg;
    logic    sat_reg;
    logic    sat_next;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_en
        assign en[i] = out_ready || !(&vld_reg[LAST:i]);
    end

    assign vld_next = {vld_reg[LAST-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // stage 0: quotient too large for the quotient register
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= ratio.divd;
            d_reg[0]   <= ratio.divs;
            neg_reg[0] <= ratio.neg;
            cop_reg[0] <= ratio.coplanar;
            for (int k = 0; k < 3; k++)
            begin
                ovf_reg[0][k] <= (ratio.divd[k] >> QUO_BITS) >= divd_t'(ratio.divs);
            end
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 1; s <= QUO_BITS; s++) begin : g_bit
        localparam int B = QUO_BITS - s;
        logic [2:0] take;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                take[k] = (rem_reg[s-1][k] >> B) >= divd_t'(d_reg[s-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                cop_reg[s] <= cop_reg[s-1];
            end
        end

        if (s == 1) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        q_reg[s][k] <= QUO_BITS'(take[k]);
                    end
                end
            end
        end
        else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        q_reg[s][k] <= {q_reg[s-1][k][QUO_BITS-2:0], take[k]};
                    end
                end
            end
        end

        if (s < QUO_BITS) begin : g_rem
            logic [2:0][DIVD_BITS-1:0] rem_sub;
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_sub[k] = take[k]
                               ? rem_reg[s-1][k] - (divd_t'(d_reg[s-1]) << B)
                               : rem_reg[s-1][k];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_sub;
                    d_reg[s]   <= d_reg[s-1];
                end
            end
        end
    end

    // last stage: sign, clipping, flat tetrahedron
    always_comb
    begin
        logic [QUO_BITS-1:0] q;
        logic                ng;
        logic                big;
        center_t             mag;
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            q   = q_reg[QUO_BITS][k];
            ng  = neg_reg[QUO_BITS][k];
            big = ovf_reg[QUO_BITS][k] || (q > (ng ? LIM_NEG : LIM_POS));
            mag = center_t'(q[CTR_BITS-1:0]);
            if (cop_reg[QUO_BITS])
            begin
                ctr_next[k] = '0;
            end
            else if (big)
            begin
                ctr_next[k] = ng ? SAT_NEG : SAT_POS;
            end
            else
            begin
                ctr_next[k] = ng ? -mag : mag;
            end
            sat_next = sat_next || (big && !cop_reg[QUO_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            ctr_reg     <= ctr_next;
            cop_out_reg <= cop_reg[QUO_BITS];
            sat_reg     <= sat_next;
        end
    end

    assign ctr       = ctr_reg;
    assign coplanar  = cop_out_reg;
    assign saturated = sat_reg;
    assign out_valid = vld_reg[LAST];
    assign in_ready  = en[0];

endmodule

// ----- sv/tetra_circumcenter_unit.sv -----
// 8 arithmetic stages and 35 divider stages lie between an accepted word and its result.
// One word per cycle unless stalled; the 33-step restoring divider is fully pipelined.
// Each stage loads when it or any later stage holds a bubble, so gaps are squeezed out
// and a stalled result does not block new words while the pipeline has room.
// Reset (rst_n low, asynchronous) clears the valid bits only; data registers keep junk.
`timescale 1ns / 1ps

module tetra_circumcenter_unit import tcc_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    tcc_in_if.sink    tetra,
    tcc_out_if.source sphere
);

    coord_t  pt [4][3];
    center_t ctr [3];
    ratio_t  ratio;
    logic    mid_valid;
    logic    mid_ready;

    assign pt[0][0] = tetra.ax;
    assign pt[0][1] = tetra.ay;
    assign pt[0][2] = tetra.az;
    assign pt[1][0] = tetra.bx;
    assign pt[1][1] = tetra.by_coord;
    assign pt[1][2] = tetra.bz;
    assign pt[2][0] = tetra.cx;
    assign pt[2][1] = tetra.cy;
    assign pt[2][2] = tetra.cz;
    assign pt[3][0] = tetra.dx;
    assign pt[3][1] = tetra.dy;
    assign pt[3][2] = tetra.dz;

    // edge vectors, cross products, volume and numerators, made into
    // an unsigned dividend/divisor pair per axis with the half-up offset folded in
    tcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tetra.valid),
        .in_ready  (tetra.ready),
        .pt        (pt),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .ratio     (ratio)
    );

    // three lanes side by side, sharing one valid chain
    tcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .ratio     (ratio),
        .out_valid (sphere.valid),
        .out_ready (sphere.ready),
        .ctr       (ctr),
        .coplanar  (sphere.coplanar),
        .saturated (sphere.saturated)
    );

    assign sphere.center_x = ctr[0];
    assign sphere.center_y = ctr[1];
    assign sphere.center_z = ctr[2];

endmodule

// ----- sv/tcc_checker.sv -----
`timescale 1ns / 1ps

module tcc_checker import tcc_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input center_t center_x,
    input center_t center_y,
    input center_t center_z,
    input logic    coplanar,
    input logic    saturated
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({center_x, center_y, center_z, coplanar, saturated}))
        else $error("result word changed while stalled");

    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && coplanar |-> center_x == '0 && center_y == '0 && center_z == '0
            && !saturated)
        else $error("flat tetrahedron with non-zero centre");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> center_x == SAT_POS || center_x == SAT_NEG
            || center_y == SAT_POS || center_y == SAT_NEG
            || center_z == SAT_POS || center_z == SAT_NEG)
        else $error("saturated flag without a clipped coordinate");

endmodule

bind tetra_circumcenter_unit tcc_checker u_tcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (sphere.valid),
    .out_ready (sphere.ready),
    .center_x  (sphere.center_x),
    .center_y  (sphere.center_y),
    .center_z  (sphere.center_z),
    .coplanar  (sphere.coplanar),
    .saturated (sphere.saturated)
);
